FILE: rtl/windowed_min_clock_offset_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed minimum clock offset filter
// Short wrappers around concurrent assertions clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MIN_CLOCK_OFFSET_DEFINES_SVH
`define WINDOWED_MIN_CLOCK_OFFSET_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define WMCO_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (conseq)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define WMCO_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (conseq)) else $error(msg);

`endif

FILE: rtl/wmco_pkg.sv
// ----------------------------------------------------------------------------
// wmco_pkg
// Types and constants of the windowed minimum clock offset filter.
// ----------------------------------------------------------------------------
package wmco_pkg;

   // transaction kinds; code 3 is unused and ignored
   typedef enum logic [1:0] {
      FUNC_FRAME  = 2'd0,
      FUNC_REBASE = 2'd1,
      FUNC_QUERY  = 2'd2
   } func_type;

   // configuration register indexes
   typedef enum logic {
      CSR_REFRESH_WINDOW = 1'b0,
      CSR_ROUND_TRIP     = 1'b1
   } csr_index_type;

   localparam int          TIME_BITS_DEFAULT   = 64;
   localparam logic [31:0] REFRESH_WINDOW_INIT = 32'd10_000_000;
   localparam logic [31:0] ROUND_TRIP_INIT     = 32'd0;
   localparam logic [31:0] LATENCY_SAT         = 32'hFFFF_FFFF;

endpackage

FILE: rtl/windowed_min_clock_offset.sv
// ----------------------------------------------------------------------------
// windowed_min_clock_offset
// Tracks the host-to-local clock offset with a windowed minimum filter and
// answers latency queries.
//
// Usage:
//  - req channel: req_func selects frame sample, rebase or latency query;
//    host and local timestamps come with it. Only queries produce a
//    transaction on the rsp channel (rsp_latency_us); the others only
//    update the offset state.
//  - csr port: refresh_window_us (index 0) and round_trip_us (index 1); the
//    user must write them only while idle, the block does not enforce it.
//  - Path: an accepted query passes through the input register and then the
//    result register, which drives rsp_valid.
//  - Throughput: one transaction per cycle, unless a query waits on rsp_stall.
//    The offset and window state is read and rewritten in the same cycle, so
//    back-to-back items see each other's updates with no bubble.
//  - Stall: while rsp_stall holds a waiting result, non-query items keep
//    flowing; a query in the input register waits and req_stall rises.
//  - Reset (synchronous): drops all items in flight, forgets the offset and
//    window, and reloads the register defaults.
// ----------------------------------------------------------------------------
`include "windowed_min_clock_offset_defines.svh"

module windowed_min_clock_offset #(
   parameter int TIME_BITS = wmco_pkg::TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_host_time_us,
   input  logic [63:0] req_local_time_us,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_latency_us,
   // configuration write port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   // estimate = sample + half - offset needs two bits over TIME_BITS
   localparam int SUM_W = TIME_BITS + 2;

   // configuration
   logic [31:0] refresh_window_ff;
   logic [31:0] round_trip_ff;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_func_ff;
   logic [TIME_BITS-1:0] s1_sample_ff;
   logic [TIME_BITS-1:0] s1_local_ff;

   // filter state
   logic [TIME_BITS-1:0] offset_ff, offset_in;
   logic [TIME_BITS-1:0] win_min_ff, win_min_in;
   logic [TIME_BITS-1:0] win_start_ff, win_start_in;
   logic                 offset_known_ff, offset_known_in;
   logic                 win_min_known_ff, win_min_known_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_latency_ff, rsp_latency_in;

   logic req_accept;
   logic s1_is_query;
   logic s1_advance;

   // ---------------------------------------------------------------------------
   // handshake: a query may only leave the input register when the result
   // register is free or draining; other kinds always leave.
   // ---------------------------------------------------------------------------
   assign s1_is_query = (s1_func_ff == wmco_pkg::FUNC_QUERY);
   assign s1_advance  = s1_valid_ff && (!s1_is_query || !rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_advance;
   assign req_accept  = req_valid && !req_stall;

   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   // ---------------------------------------------------------------------------
   // filter update and latency estimate, one item per cycle unless a query is held
   // ---------------------------------------------------------------------------
   logic                 smp_lt_wmin, smp_lt_off;
   logic [TIME_BITS-1:0] wmin_new;
   logic [TIME_BITS-1:0] off_new;
   logic [TIME_BITS-1:0] start_new;
   logic [TIME_BITS-1:0] age;
   logic [TIME_BITS+31:0] age_wide, refresh_wide;
   logic                 expired;
   logic signed [SUM_W-1:0] smp_ext, half_ext, off_ext, est_sum, sat_ext;

   always_comb begin
      // frame: window minimum tracks the smallest sample, offset follows
      // any smaller sample immediately
      smp_lt_wmin = $signed(s1_sample_ff) < $signed(win_min_ff);
      smp_lt_off  = $signed(s1_sample_ff) < $signed(offset_ff);
      wmin_new    = (!win_min_known_ff || smp_lt_wmin) ? s1_sample_ff : win_min_ff;
      off_new     = (!offset_known_ff || smp_lt_off) ? s1_sample_ff : offset_ff;
      start_new   = offset_known_ff ? win_start_ff : s1_local_ff;

      // window age, modulo 2^TIME_BITS; zero on the seeding sample
      age          = s1_local_ff - start_new;
      age_wide     = {32'd0, age};
      refresh_wide = {{TIME_BITS{1'b0}}, refresh_window_ff};
      expired      = (age_wide >= refresh_wide);

      offset_in        = offset_ff;
      win_min_in       = win_min_ff;
      win_start_in     = win_start_ff;
      offset_known_in  = offset_known_ff;
      win_min_known_in = win_min_known_ff;

      if (s1_advance) begin
         case (s1_func_ff)
            wmco_pkg::FUNC_FRAME: begin
               offset_known_in = 1'b1;
               win_min_in      = wmin_new;
               if (expired) begin
                  // window ran out: its minimum becomes the offset
                  offset_in        = wmin_new;
                  win_start_in     = s1_local_ff;
                  win_min_known_in = 1'b0;
               end else begin
                  offset_in        = off_new;
                  win_start_in     = start_new;
                  win_min_known_in = 1'b1;
               end
            end
            wmco_pkg::FUNC_REBASE: begin
               offset_in        = s1_sample_ff;
               win_min_in       = s1_sample_ff;
               win_start_in     = s1_local_ff;
               offset_known_in  = 1'b1;
               win_min_known_in = 1'b1;
            end
            default: begin
               // query and unused code leave the state alone
            end
         endcase
      end

      // exact estimate: sample - offset + round_trip / 2
      smp_ext  = {{2{s1_sample_ff[TIME_BITS-1]}}, s1_sample_ff};
      off_ext  = {{2{offset_ff[TIME_BITS-1]}}, offset_ff};
      half_ext = {{(SUM_W-31){1'b0}}, round_trip_ff[31:1]};
      sat_ext  = {{(SUM_W-32){1'b0}}, wmco_pkg::LATENCY_SAT};
      est_sum  = smp_ext + half_ext - off_ext;

      if (!offset_known_ff || est_sum <= $signed({SUM_W{1'b0}})) begin
         rsp_latency_in = 32'd0;
      end else if (est_sum > sat_ext) begin
         rsp_latency_in = wmco_pkg::LATENCY_SAT;
      end else begin
         rsp_latency_in = est_sum[31:0];
      end

      if (s1_advance && s1_is_query) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // ---------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_window_ff <= wmco_pkg::REFRESH_WINDOW_INIT;
         round_trip_ff     <= wmco_pkg::ROUND_TRIP_INIT;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         offset_ff         <= '0;
         win_min_ff        <= '0;
         win_start_ff      <= '0;
         offset_known_ff   <= 1'b0;
         win_min_known_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               wmco_pkg::CSR_REFRESH_WINDOW: refresh_window_ff <= csr_wdata;
               wmco_pkg::CSR_ROUND_TRIP:     round_trip_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         offset_ff        <= offset_in;
         win_min_ff       <= win_min_in;
         win_start_ff     <= win_start_in;
         offset_known_ff  <= offset_known_in;
         win_min_known_ff <= win_min_known_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff   <= req_func;
         s1_sample_ff <= req_local_time_us[TIME_BITS-1:0] - req_host_time_us[TIME_BITS-1:0];
         s1_local_ff  <= req_local_time_us[TIME_BITS-1:0];
      end
      if (s1_advance && s1_is_query) begin
         rsp_latency_ff <= rsp_latency_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_latency_us = rsp_latency_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   `WMCO_ASSERT_NEXT(a_query_gives_result, s1_advance && s1_is_query, rsp_valid,
      "query left input register without producing a result")
   `WMCO_ASSERT_NOW(a_query_held_on_stall,
      s1_valid_ff && s1_is_query && rsp_valid_ff && rsp_stall, req_stall,
      "query overran a stalled result")
   `WMCO_ASSERT_NEXT(a_offset_known_after_update,
      s1_advance && (s1_func_ff == wmco_pkg::FUNC_FRAME ||
                     s1_func_ff == wmco_pkg::FUNC_REBASE),
      offset_known_ff, "offset not known after frame or rebase")
   `WMCO_ASSERT_NEXT(a_zero_without_offset,
      s1_advance && s1_is_query && !offset_known_ff, rsp_latency_us == 32'd0,
      "nonzero latency with no known offset")

endmodule
